### rtl/pbca_pkg.sv
`default_nettype none

package pbca_pkg;

   // operation codes held in the op_mode register
   typedef enum logic [2:0] {
      OP_MULTIPLY = 3'd0,
      OP_SUBTRACT = 3'd1,
      OP_SCREEN   = 3'd2,
      OP_OVERLAY  = 3'd3,
      OP_ADD      = 3'd4,
      OP_SCALE    = 3'd5
   } op_mode_type;

   // configuration register indexes
   localparam logic [1:0] CSR_OP_MODE        = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_SELECT = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_AMOUNT = 2'd2;

   // channel selector codes
   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_RED   = 2'd2;

   // floor(y / 255) = q0 or q0 + 1, with q0 = (y * RECIP_255) >> RECIP_SHIFT
   localparam logic [14:0] RECIP_255   = 15'd16448;
   localparam int          RECIP_SHIFT = 22;

   // what a lane does with its word once the operands are formed
   typedef enum logic [1:0] {
      KIND_BLEND,
      KIND_SCALE,
      KIND_DIRECT
   } lane_kind_type;

   // per-lane control from the configuration registers
   typedef struct packed {
      logic [2:0]          op_mode;
      logic                selected;
      logic signed [8:0]   amount;
   } lane_ctrl_type;

endpackage

`default_nettype wire

### rtl/pixel_blend_and_channel_adjust.sv
`default_nettype none

// channel  | direction | ports                                  | handshake
// ---------+-----------+----------------------------------------+----------------
// req      | in        | top_* / bottom_* (8 bits each)         | req_valid/ready
// rsp      | out       | out_blue / out_green / out_red         | rsp_valid/ready
// csr      | in        | csr_index (2 bits), csr_data (9 bits)  | csr_valid/ready
//
// one word per cycle sustained while rsp_ready stays high; each word passes
// through two lane stages and then the merged result register
// the whole pipeline moves together: it advances when the result register
// is empty or being taken, so req_ready follows rsp_ready through one gate
// synchronous reset clears the valid bits and loads the register defaults
// csr writes are always taken; index three is ignored

module pixel_blend_and_channel_adjust (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_top_blue,
   input  wire logic [7:0] req_top_green,
   input  wire logic [7:0] req_top_red,
   input  wire logic [7:0] req_bottom_blue,
   input  wire logic [7:0] req_bottom_green,
   input  wire logic [7:0] req_bottom_red,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_blue,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_red,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data
);

   // configuration registers
   logic [2:0]        op_mode_ff;
   logic [1:0]        chan_sel_ff;
   logic signed [8:0] amount_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff  <= pbca_pkg::OP_MULTIPLY;
         chan_sel_ff <= pbca_pkg::CHAN_RED;
         amount_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pbca_pkg::CSR_OP_MODE:        op_mode_ff  <= csr_data[2:0];
            pbca_pkg::CSR_CHANNEL_SELECT: chan_sel_ff <= csr_data[1:0];
            pbca_pkg::CSR_CHANNEL_AMOUNT: amount_ff   <= $signed(csr_data);
            default: begin
               // out-of-range index, write dropped
            end
         endcase
      end
   end

   // global pipeline advance
   logic advance;
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // one lane per color channel; only the selected lane sees add/scale
   pbca_pkg::lane_ctrl_type ctrl_blue, ctrl_green, ctrl_red;
   logic [7:0]              lane_blue, lane_green, lane_red;

   always_comb begin
      ctrl_blue.op_mode   = op_mode_ff;
      ctrl_blue.amount    = amount_ff;
      ctrl_blue.selected  = (chan_sel_ff == pbca_pkg::CHAN_BLUE);
      ctrl_green.op_mode  = op_mode_ff;
      ctrl_green.amount   = amount_ff;
      ctrl_green.selected = (chan_sel_ff == pbca_pkg::CHAN_GREEN);
      ctrl_red.op_mode    = op_mode_ff;
      ctrl_red.amount     = amount_ff;
      ctrl_red.selected   = (chan_sel_ff == pbca_pkg::CHAN_RED);
   end

   pbca_lane u_lane_blue (
      .clock      (clock),
      .advance    (advance),
      .ctrl       (ctrl_blue),
      .top_pix    (req_top_blue),
      .bottom_pix (req_bottom_blue),
      .result     (lane_blue)
   );

   pbca_lane u_lane_green (
      .clock      (clock),
      .advance    (advance),
      .ctrl       (ctrl_green),
      .top_pix    (req_top_green),
      .bottom_pix (req_bottom_green),
      .result     (lane_green)
   );

   pbca_lane u_lane_red (
      .clock      (clock),
      .advance    (advance),
      .ctrl       (ctrl_red),
      .top_pix    (req_top_red),
      .bottom_pix (req_bottom_red),
      .result     (lane_red)
   );

   // merge stage: the three lane results form one output word
   logic [7:0] out_blue_ff, out_green_ff, out_red_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_blue_ff  <= lane_blue;
         out_green_ff <= lane_green;
         out_red_ff   <= lane_red;
      end
   end

   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_red   = out_red_ff;

endmodule

`default_nettype wire

### rtl/pbca_lane.sv
`default_nettype none

module pbca_lane (
   input  wire logic                    clock,
   input  wire logic                    advance,
   input  wire pbca_pkg::lane_ctrl_type ctrl,
   input  wire logic [7:0]              top_pix,
   input  wire logic [7:0]              bottom_pix,
   output logic [7:0]                   result
);

   // stage 1: operand select, one shared 9x9 signed multiplier
   pbca_pkg::lane_kind_type kind_in, kind1_ff, kind2_in, kind2_ff;
   logic                    comp_in, comp1_ff, comp2_ff;
   logic                    quad_in, quad1_ff;
   logic [7:0]              direct_in, direct1_ff, direct2_in, direct2_ff;
   logic [7:0]              mul_a;
   logic signed [8:0]       mul_b;
   logic signed [17:0]      prod_in, prod1_ff;
   logic [8:0]              diff;
   logic signed [9:0]       add_sum;

   always_comb begin
      diff    = {1'b0, top_pix} - {1'b0, bottom_pix};
      add_sum = $signed({2'b00, top_pix}) + {ctrl.amount[8], ctrl.amount};
      kind_in   = pbca_pkg::KIND_DIRECT;
      comp_in   = 1'b0;
      quad_in   = 1'b0;
      direct_in = top_pix;
      mul_a     = top_pix;
      mul_b     = $signed({1'b0, bottom_pix});
      unique case (ctrl.op_mode)
         pbca_pkg::OP_MULTIPLY: begin
            kind_in = pbca_pkg::KIND_BLEND;
         end
         pbca_pkg::OP_SUBTRACT: begin
            direct_in = diff[8] ? 8'd0 : diff[7:0];
         end
         pbca_pkg::OP_SCREEN: begin
            kind_in = pbca_pkg::KIND_BLEND;
            comp_in = 1'b1;
            mul_a   = ~top_pix;
            mul_b   = $signed({1'b0, ~bottom_pix});
         end
         pbca_pkg::OP_OVERLAY: begin
            kind_in = pbca_pkg::KIND_BLEND;
            quad_in = 1'b1;
            if (bottom_pix[7]) begin
               comp_in = 1'b1;
               mul_a   = ~top_pix;
               mul_b   = $signed({1'b0, ~bottom_pix});
            end
         end
         pbca_pkg::OP_ADD: begin
            if (ctrl.selected) begin
               if (add_sum[9])
                  direct_in = 8'd0;
               else if (add_sum[8])
                  direct_in = 8'hFF;
               else
                  direct_in = add_sum[7:0];
            end
         end
         pbca_pkg::OP_SCALE: begin
            if (ctrl.selected) begin
               kind_in = pbca_pkg::KIND_SCALE;
               mul_b   = ctrl.amount;
            end
         end
         default: begin
            kind_in = pbca_pkg::KIND_DIRECT;
         end
      endcase
      prod_in = $signed({1'b0, mul_a}) * mul_b;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind1_ff   <= kind_in;
         comp1_ff   <= comp_in;
         quad1_ff   <= quad_in;
         direct1_ff <= direct_in;
         prod1_ff   <= prod_in;
      end
   end

   // stage 2: rounding offset, halve, reciprocal multiply by 1/255; clamp of scale products
   logic [17:0] round_sum;
   logic [16:0] half_in, half2_ff;
   logic [31:0] recip_prod;
   logic [9:0]  q0_in, q0_ff;

   always_comb begin
      round_sum  = (quad1_ff ? {prod1_ff[15:0], 2'b00} : {1'b0, prod1_ff[15:0], 1'b0})
                   + 18'd255;
      half_in    = round_sum[17:1];
      recip_prod = {15'd0, half_in} * {17'd0, pbca_pkg::RECIP_255};
      q0_in      = recip_prod[pbca_pkg::RECIP_SHIFT +: 10];
      kind2_in   = kind1_ff;
      direct2_in = direct1_ff;
      if (kind1_ff == pbca_pkg::KIND_SCALE) begin
         kind2_in = pbca_pkg::KIND_DIRECT;
         if (prod1_ff[17])
            direct2_in = 8'd0;
         else if (prod1_ff[16:8] != 9'd0)
            direct2_in = 8'hFF;
         else
            direct2_in = prod1_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind2_ff   <= kind2_in;
         comp2_ff   <= comp1_ff;
         direct2_ff <= direct2_in;
         half2_ff   <= half_in;
         q0_ff      <= q0_in;
      end
   end

   // stage 3: quotient correction, complement for screen-style results
   logic [17:0] q0_times;
   logic [17:0] rem;
   logic [9:0]  quot;
   logic [7:0]  blend_val;

   always_comb begin
      q0_times  = {q0_ff, 8'd0} - {8'd0, q0_ff};
      rem       = {1'b0, half2_ff} - q0_times;
      quot      = (rem >= 18'd255) ? q0_ff + 10'd1 : q0_ff;
      blend_val = comp2_ff ? ~quot[7:0] : quot[7:0];
      result    = (kind2_ff == pbca_pkg::KIND_BLEND) ? blend_val : direct2_ff;
   end

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   // one pixel as three lanes: [0] blue, [1] green, [2] red
   typedef logic [2:0][7:0] pixel_type;

   // codes the package leaves unnamed: spare op codes, no channel, spare csr slot
   localparam logic [2:0] OP_SPARE_6  = 3'd6;
   localparam logic [2:0] OP_SPARE_7  = 3'd7;
   localparam logic [1:0] CHAN_NONE   = 2'd3;
   localparam logic [1:0] CSR_SPARE   = 2'd3;

   localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int RANDOM_WORDS = 660;
   localparam int DRAIN_CYCLES = 8;      // pipeline is three deep, leave some slack

   // expected-pixel store plus its own copy of the three csr registers
   class blend_scoreboard;
      logic [2:0]        op_reg;
      logic [1:0]        chan_reg;
      logic signed [8:0] amount_reg;
      pixel_type         expected_q[$];
      int                words_done;
      int                errors;
      string             lane_name[3] = '{"blue", "green", "red"};

      function new();
         op_reg     = pbca_pkg::OP_MULTIPLY;
         chan_reg   = pbca_pkg::CHAN_RED;
         amount_reg = '0;
         words_done = 0;
         errors     = 0;
      endfunction

      // csr write; the spare index leaves everything alone
      function void write_reg(logic [1:0] index, logic [8:0] data);
         unique case (index)
            pbca_pkg::CSR_OP_MODE:        op_reg     = data[2:0];
            pbca_pkg::CSR_CHANNEL_SELECT: chan_reg   = data[1:0];
            pbca_pkg::CSR_CHANNEL_AMOUNT: amount_reg = data;
            default: ;
         endcase
      endfunction

      function logic [7:0] clamp_byte(int v);
         if (v < 0)
            return 8'd0;
         if (v > 255)
            return 8'd255;
         return 8'(v);
      endfunction

      // one lane of the four blend ops, exact integer rounding
      function logic [7:0] blend_lane(logic [7:0] t, logic [7:0] b);
         int ti;
         int bi;
         int ct;
         int cb;
         ti = t;
         bi = b;
         ct = 255 - ti;
         cb = 255 - bi;
         unique case (op_reg)
            pbca_pkg::OP_MULTIPLY: return 8'((2 * ti * bi + 255) / 510);
            pbca_pkg::OP_SUBTRACT: return clamp_byte(ti - bi);
            pbca_pkg::OP_SCREEN:   return 8'(255 - (2 * ct * cb + 255) / 510);
            pbca_pkg::OP_OVERLAY: begin
               if (bi >= 128)
                  return 8'(255 - (4 * ct * cb + 255) / 510);
               else
                  return 8'((4 * ti * bi + 255) / 510);
            end
            default:     return t;
         endcase
      endfunction

      function pixel_type blend_pixel(pixel_type top, pixel_type bottom);
         pixel_type res;
         int        t;
         int        k;
         res = top;
         if (op_reg <= pbca_pkg::OP_OVERLAY) begin
            for (k = 0; k < 3; k++)
               res[k] = blend_lane(top[k], bottom[k]);
         end else if ((op_reg == pbca_pkg::OP_ADD || op_reg == pbca_pkg::OP_SCALE)
                      && chan_reg != CHAN_NONE) begin
            t = top[chan_reg];
            if (op_reg == pbca_pkg::OP_ADD)
               res[chan_reg] = clamp_byte(t + amount_reg);
            else
               res[chan_reg] = clamp_byte(t * amount_reg);
         end
         return res;
      endfunction

      function void note_pixel(pixel_type top, pixel_type bottom);
         expected_q.insert(expected_q.size(), blend_pixel(top, bottom));
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_pixel(pixel_type got);
         pixel_type want;
         int        k;
         if (expected_q.size() == 0) begin
            report($sformatf("result word %0h with none expected", got));
            return;
         end
         want = expected_q.pop_front();
         words_done++;
         for (k = 0; k < 3; k++)
            if (got[k] !== want[k])
               report($sformatf("word %0d out_%s expected %0d got %0d",
                                words_done, lane_name[k], want[k], got[k]));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;

   logic       req_valid;
   logic       req_ready;
   pixel_type  req_top;
   pixel_type  req_bottom;

   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_red;

   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [8:0] csr_data;

   blend_scoreboard sb = new();

   int  words_sent = 0;
   int  settings_used = 0;
   int  spare_writes = 0;
   int  idle_cycles = 0;
   int  words_per_op[8] = '{default: 0};
   bit  quiet_phase = 1'b0;   // both sides stop idling while set

   pixel_blend_and_channel_adjust dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_top_blue     (req_top[0]),
      .req_top_green    (req_top[1]),
      .req_top_red      (req_top[2]),
      .req_bottom_blue  (req_bottom[0]),
      .req_bottom_green (req_bottom[1]),
      .req_bottom_red   (req_bottom[2]),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // monitor: all handshakes are sampled at the edge, before any nba lands
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         // csr and pixel words never share an edge, so order here is free
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) begin
            words_per_op[sb.op_reg]++;
            sb.note_pixel(req_top, req_bottom);
         end
         if (rsp_valid && rsp_ready)
            sb.check_pixel({rsp_out_red, rsp_out_green, rsp_out_blue});

         // watchdog on cycles with no progress on any channel
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d of %0d words back",
                     STALL_LIMIT, sb.words_done, words_sent);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result side: random stall before each word, none in quiet phases
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         // stays high through back-to-back words when stall is zero
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
      end
   end

   // corner values get extra weight so every lane sees 0, 255 and the 127/128 split
   function automatic logic [7:0] rand_byte();
      logic [7:0] byte_corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      if ($urandom_range(3) == 0)
         return byte_corners[$urandom_range(5)];
      return 8'($urandom_range(255));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int        k;
      for (k = 0; k < 3; k++)
         p[k] = rand_byte();
      return p;
   endfunction

   // one pixel word: optional gap with valid low, then hold until taken
   task automatic send_pixel(pixel_type top, pixel_type bottom);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_top    <= top;
      req_bottom <= bottom;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
   endtask

   // csr_valid is left high so consecutive writes do not toggle it in one step
   task automatic write_csr(logic [1:0] index, logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // new register setting, only once the pipeline has handed back every word
   task automatic apply_setting(logic [2:0] op, logic [1:0] chan, int amount,
                                logic [2:0] write_mask, bit hit_spare);
      req_valid <= 1'b0;
      while (sb.words_done != words_sent)
         @(posedge clock);
      // junk in the unused upper data bits must be dropped by the block
      if (write_mask[0])
         write_csr(pbca_pkg::CSR_OP_MODE, {6'($urandom), op});
      if (write_mask[1])
         write_csr(pbca_pkg::CSR_CHANNEL_SELECT, {7'($urandom), chan});
      if (write_mask[2])
         write_csr(pbca_pkg::CSR_CHANNEL_AMOUNT, 9'(amount));
      if (hit_spare) begin
         write_csr(CSR_SPARE, 9'($urandom));
         spare_writes++;
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // three fixed pixel pairs: the blue and green lanes see 0 and 255 on both layers,
   // and the bottom lanes straddle the overlay split at 128
   task automatic send_corners();
      send_pixel({8'd128, 8'd255, 8'd0},   {8'd128, 8'd0, 8'd255});
      send_pixel({8'd127, 8'd0, 8'd255},   {8'd0, 8'd255, 8'd127});
      send_pixel({8'd1, 8'd255, 8'd255},   {8'd128, 8'd255, 8'd0});
   endtask

   initial begin
      int         random_words;
      int         n;
      int         amount;
      logic [2:0] op;
      logic [1:0] chan;
      logic [2:0] write_mask;
      int         amount_corners[6];

      amount_corners = '{-256, -255, -1, 0, 1, 255};
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_top    <= '0;
      req_bottom <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults first (multiply), then each op in turn
      send_corners();
      apply_setting(pbca_pkg::OP_SUBTRACT, pbca_pkg::CHAN_RED, 0, 3'b111, 1'b0);
      send_corners();
      apply_setting(pbca_pkg::OP_SCREEN, pbca_pkg::CHAN_RED, 0, 3'b111, 1'b0);
      send_corners();
      apply_setting(pbca_pkg::OP_OVERLAY, pbca_pkg::CHAN_RED, 0, 3'b111, 1'b0);
      send_corners();
      // add clamps high on blue
      apply_setting(pbca_pkg::OP_ADD, pbca_pkg::CHAN_BLUE, 255, 3'b111, 1'b0);
      send_corners();
      // most negative factor, clamps low on red
      apply_setting(pbca_pkg::OP_SCALE, pbca_pkg::CHAN_RED, -256, 3'b111, 1'b0);
      send_corners();
      // scale with no channel selected passes the top pixel; spare index ignored
      apply_setting(pbca_pkg::OP_SCALE, CHAN_NONE, 255, 3'b111, 1'b1);
      send_corners();
      // unused op codes pass the top pixel
      apply_setting(OP_SPARE_6, pbca_pkg::CHAN_GREEN, 1, 3'b111, 1'b0);
      send_corners();
      apply_setting(OP_SPARE_7, pbca_pkg::CHAN_GREEN, -1, 3'b001, 1'b0);
      send_corners();

      // random phases: new setting, then a burst of random pixels
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         quiet_phase = ($urandom_range(3) == 0);
         op   = 3'($urandom_range(7));
         chan = 2'($urandom_range(3));
         if ($urandom_range(2) == 0)
            amount = amount_corners[$urandom_range(5)];
         else
            amount = $urandom_range(511) - 256;
         // now and then leave some registers as they were
         write_mask = ($urandom_range(3) == 0) ? 3'($urandom) : 3'b111;
         apply_setting(op, chan, amount, write_mask, $urandom_range(5) == 0);
         n = $urandom_range(15, 35);
         repeat (n)
            send_pixel(random_pixel(), random_pixel());
         random_words += n;
      end

      // drain, then a few idle cycles to catch stray result words
      req_valid <= 1'b0;
      while (sb.words_done != words_sent)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d expected words never came back", sb.expected_q.size()));

      $display("run covered %0d pixel words over %0d register settings, %0d spare csr writes",
               words_sent, settings_used, spare_writes);
      $display("words per op code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               words_per_op[0], words_per_op[1], words_per_op[2], words_per_op[3],
               words_per_op[4], words_per_op[5], words_per_op[6], words_per_op[7]);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
